// ===== sv/trs_tc_pkg.sv =====
`default_nettype none
package trs_tc_pkg;

    // One bit of the reciprocal quotient is settled in each divider stage.
    localparam int unsigned DivSteps = 33;
    // Width of a rotation entry in Q.27.
    localparam int unsigned RotW = 34;

    localparam logic [1:0] OpFwd     = 2'd0;
    localparam logic [1:0] OpAxes    = 2'd1;
    localparam logic [1:0] OpInv     = 2'd2;
    localparam logic [1:0] OpInvAxes = 2'd3;

    localparam logic signed [31:0] SatMax = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SatMin = 32'sh80000000;

    // Quaternion order: w, x, y, z.
    typedef struct packed {
        logic [1:0]       op;
        logic [2:0][31:0] trans;
        logic [2:0][31:0] scale;
        logic [3:0][31:0] quat;
    } t_item;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sh7FFFFFFF) begin
            res = SatMax;
        end else if (v < -66'sh80000000) begin
            res = SatMin;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/trs_tc_div.sv =====
`default_nettype none
module trs_tc_div
    import trs_tc_pkg::*;
(
    input  wire  logic             i_clk,
    input  wire  logic             i_rst_n,
    input  wire  logic             i_en,
    input  wire  logic             i_valid,
    input  wire  t_item            i_item,
    output logic                   o_valid,
    output t_item                  o_item,
    output logic [2:0][32:0]       o_quo,
    output logic [2:0]             o_neg,
    output logic [2:0]             o_zero
);

    logic             r_v    [0:DivSteps];
    t_item            r_it   [0:DivSteps];
    logic [2:0][31:0] r_rem  [0:DivSteps];
    logic [2:0][32:0] r_quo  [0:DivSteps];
    logic [2:0][31:0] r_dv   [0:DivSteps];
    logic [2:0]       r_neg  [0:DivSteps];
    logic [2:0]       r_zero [0:DivSteps];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // The divisor is the magnitude of the scale; the sign is applied later.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_it[0] <= i_item;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l]  <= '0;
                r_quo[0][l]  <= '0;
                r_dv[0][l]   <= i_item.scale[l][31] ? 32'(-i_item.scale[l])
                                                    : i_item.scale[l];
                r_neg[0][l]  <= i_item.scale[l][31];
                r_zero[0][l] <= (i_item.scale[l] == '0);
            end
        end
    end

    for (genvar k = 1; k <= DivSteps; k++) begin : g_step
        // The dividend is 2^32, so only the first step brings in a one.
        localparam logic InBit = (k == 1) ? 1'b1 : 1'b0;
        logic [2:0][31:0] n_rem;
        logic [2:0][32:0] n_quo;

        always_comb begin
            logic [32:0] trial;
            logic        ge;
            for (int l = 0; l < 3; l++) begin
                trial    = {r_rem[k-1][l], InBit};
                ge       = (trial >= {1'b0, r_dv[k-1][l]});
                n_rem[l] = ge ? 32'(trial - {1'b0, r_dv[k-1][l]}) : trial[31:0];
                n_quo[l] = {r_quo[k-1][l][31:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_it[k]   <= r_it[k-1];
                r_rem[k]  <= n_rem;
                r_quo[k]  <= n_quo;
                r_dv[k]   <= r_dv[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    assign o_valid = r_v[DivSteps];
    assign o_item  = r_it[DivSteps];
    assign o_quo   = r_quo[DivSteps];
    assign o_neg   = r_neg[DivSteps];
    assign o_zero  = r_zero[DivSteps];

endmodule
`default_nettype wire

// ===== sv/trs_tc_rot.sv =====
`default_nettype none
module trs_tc_rot
    import trs_tc_pkg::*;
(
    input  wire  logic                  i_clk,
    input  wire  logic                  i_rst_n,
    input  wire  logic                  i_en,
    input  wire  logic                  i_valid,
    input  wire  t_item                 i_item,
    input  wire  logic [2:0][32:0]      i_quo,
    input  wire  logic [2:0]            i_neg,
    input  wire  logic [2:0]            i_zero,
    output logic                        o_valid,
    output logic [1:0]                  o_op,
    output logic [2:0][31:0]            o_trans,
    output logic [2:0][31:0]            o_scale,
    output logic [8:0][RotW-1:0]        o_rot
);

    function automatic logic signed [65:0] half(input logic signed [63:0] p,
                                                input logic ng);
        logic signed [65:0] e;
        e = 66'(p);
        if (ng) begin
            e = -e;
        end
        return e >>> 1;
    endfunction

    // Stage A: scale or reciprocal, and the nine quaternion products.
    logic                     r_v_a;
    logic [1:0]               r_op_a;
    logic [2:0][31:0]         r_trans_a;
    logic [2:0][31:0]         r_scale_a;
    logic signed [63:0]       r_pxx, r_pyy, r_pzz, r_pxy, r_pxz, r_pyz;
    logic signed [63:0]       r_pwx, r_pwy, r_pwz;
    logic [2:0][31:0]         n_scale_a;

    logic signed [31:0] qw, qx, qy, qz;
    assign qw = $signed(i_item.quat[0]);
    assign qx = $signed(i_item.quat[1]);
    assign qy = $signed(i_item.quat[2]);
    assign qz = $signed(i_item.quat[3]);

    always_comb begin
        logic signed [34:0] sv;
        logic signed [31:0] rec;
        for (int l = 0; l < 3; l++) begin
            sv  = i_neg[l] ? -$signed({2'b00, i_quo[l]}) : $signed({2'b00, i_quo[l]});
            rec = i_zero[l] ? SatMax : sat32(66'(sv));
            n_scale_a[l] = i_item.op[1] ? rec : i_item.scale[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
        end else if (i_en) begin
            r_v_a <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_a    <= i_item.op;
            r_trans_a <= i_item.trans;
            r_scale_a <= n_scale_a;
            r_pxx     <= qx * qx;
            r_pyy     <= qy * qy;
            r_pzz     <= qz * qz;
            r_pxy     <= qx * qy;
            r_pxz     <= qx * qz;
            r_pyz     <= qy * qz;
            r_pwx     <= qw * qx;
            r_pwy     <= qw * qy;
            r_pwz     <= qw * qz;
        end
    end

    // Stage B: rotation entries. The conjugate flips the sign of every
    // product that involves w.
    logic                   r_v_b;
    logic [1:0]             r_op_b;
    logic [2:0][31:0]       r_trans_b;
    logic [2:0][31:0]       r_scale_b;
    logic [8:0][RotW-1:0]   r_rot_b;
    logic [8:0][RotW-1:0]   n_rot;

    always_comb begin
        logic               cj;
        logic signed [65:0] one;
        cj  = r_op_a[1];
        one = 66'sh0400000000000000;
        n_rot[0] = RotW'((one - (half(r_pyy, 1'b0) + half(r_pzz, 1'b0))) >>> 31);
        n_rot[1] = RotW'((half(r_pxy, 1'b0) + half(r_pwz, cj)) >>> 31);
        n_rot[2] = RotW'((half(r_pxz, 1'b0) + half(r_pwy, !cj)) >>> 31);
        n_rot[3] = RotW'((half(r_pxy, 1'b0) + half(r_pwz, !cj)) >>> 31);
        n_rot[4] = RotW'((one - (half(r_pxx, 1'b0) + half(r_pzz, 1'b0))) >>> 31);
        n_rot[5] = RotW'((half(r_pyz, 1'b0) + half(r_pwx, cj)) >>> 31);
        n_rot[6] = RotW'((half(r_pxz, 1'b0) + half(r_pwy, cj)) >>> 31);
        n_rot[7] = RotW'((half(r_pyz, 1'b0) + half(r_pwx, !cj)) >>> 31);
        n_rot[8] = RotW'((one - (half(r_pxx, 1'b0) + half(r_pyy, 1'b0))) >>> 31);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_b <= 1'b0;
        end else if (i_en) begin
            r_v_b <= r_v_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_b    <= r_op_a;
            r_trans_b <= r_trans_a;
            r_scale_b <= r_scale_a;
            r_rot_b   <= n_rot;
        end
    end

    assign o_valid = r_v_b;
    assign o_op    = r_op_b;
    assign o_trans = r_trans_b;
    assign o_scale = r_scale_b;
    assign o_rot   = r_rot_b;

`ifndef ASSERT_OFF
    a_zero_scale_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_valid && i_item.op[1] && i_zero[0] |=> r_scale_a[0] == SatMax)
        else $error("zero scale did not saturate its reciprocal");

    a_valid_a_to_b : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_v_a |=> r_v_b)
        else $error("item lost between rotation stages");
`endif

endmodule
`default_nettype wire

// ===== sv/trs_tc_lin.sv =====
`default_nettype none
module trs_tc_lin
    import trs_tc_pkg::*;
(
    input  wire  logic                  i_clk,
    input  wire  logic                  i_rst_n,
    input  wire  logic                  i_en,
    input  wire  logic                  i_valid,
    input  wire  logic [1:0]            i_op,
    input  wire  logic [2:0][31:0]      i_trans,
    input  wire  logic [2:0][31:0]      i_scale,
    input  wire  logic [8:0][RotW-1:0]  i_rot,
    output logic                        o_valid,
    output logic [8:0][31:0]            o_m,
    output logic [2:0][31:0]            o_t
);

    // Stage C: rotation times scale, by column or by row.
    logic               r_v_c;
    logic [1:0]         r_op_c;
    logic [2:0][31:0]   r_trans_c;
    logic [8:0][65:0]   r_pc;
    logic [8:0][65:0]   n_pc;

    always_comb begin
        logic signed [65:0] pr;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (i_op == OpFwd || i_op == OpInvAxes) begin
                    pr = $signed(i_rot[c*3+r]) * $signed(i_scale[c]);
                end else begin
                    pr = $signed(i_rot[c*3+r]) * $signed(i_scale[r]);
                end
                n_pc[c*3+r] = pr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_c <= 1'b0;
        end else if (i_en) begin
            r_v_c <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_c    <= i_op;
            r_trans_c <= i_trans;
            r_pc      <= n_pc;
        end
    end

    // Stage D: saturate the linear part, negate the translation if inverse.
    logic               r_v_d;
    logic [1:0]         r_op_d;
    logic [2:0][32:0]   r_t_d;
    logic [8:0][31:0]   r_m_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_d <= 1'b0;
        end else if (i_en) begin
            r_v_d <= r_v_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_d <= r_op_c;
            for (int i = 0; i < 9; i++) begin
                r_m_d[i] <= sat32($signed(r_pc[i]) >>> 27);
            end
            for (int l = 0; l < 3; l++) begin
                r_t_d[l] <= r_op_c[1] ? -33'($signed(r_trans_c[l]))
                                      : 33'($signed(r_trans_c[l]));
            end
        end
    end

    // Stage E: products of the linear part with the translation.
    logic               r_v_e;
    logic [1:0]         r_op_e;
    logic [8:0][31:0]   r_m_e;
    logic [8:0][64:0]   r_tp;
    logic [2:0][31:0]   r_dir;
    logic [8:0][64:0]   n_tp;

    always_comb begin
        logic signed [64:0] pr;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                pr = $signed(r_m_d[c*3+r]) * $signed(r_t_d[c]);
                n_tp[c*3+r] = pr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_e <= 1'b0;
        end else if (i_en) begin
            r_v_e <= r_v_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op_e <= r_op_d;
            r_m_e  <= r_m_d;
            r_tp   <= n_tp;
            for (int l = 0; l < 3; l++) begin
                r_dir[l] <= sat32(66'($signed(r_t_d[l])));
            end
        end
    end

    // Stage F: sum over columns and pick the translation for the mode.
    logic               r_v_f;
    logic [8:0][31:0]   r_m_f;
    logic [2:0][31:0]   r_t_f;
    logic [2:0][31:0]   n_t;

    always_comb begin
        logic signed [65:0] acc;
        for (int r = 0; r < 3; r++) begin
            acc = '0;
            for (int c = 0; c < 3; c++) begin
                acc = acc + 66'($signed(r_tp[c*3+r]) >>> 16);
            end
            if (r_op_e == OpAxes || r_op_e == OpInv) begin
                n_t[r] = sat32(acc);
            end else begin
                n_t[r] = r_dir[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_f <= 1'b0;
        end else if (i_en) begin
            r_v_f <= r_v_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_f <= r_m_e;
            r_t_f <= n_t;
        end
    end

    assign o_valid = r_v_f;
    assign o_m     = r_m_f;
    assign o_t     = r_t_f;

`ifndef ASSERT_OFF
    a_valid_e_to_f : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && r_v_e |=> r_v_f)
        else $error("item lost before the output register");

    a_hold_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(r_t_f) && $stable(r_m_f))
        else $error("output register changed while the pipeline was held");
`endif

endmodule
`default_nettype wire

// ===== sv/trs_transform_compose_unit.sv =====
// Transform composer: turns a translation, a per-axis scale and a rotation
// quaternion into one 3x4 affine matrix in Q16.16, with no state kept
// between items.
// Input channel: i_valid / o_ready carry i_op, i_trans_*, i_scale_* and
// i_quat_*. Output channel: o_valid / i_ready carry the nine linear entries
// o_m_cC_rR and the translation column o_out_t*.
// An item passes 40 register stages on its way to o_valid: one input
// register, 33 divider stages that build the reciprocal scale one quotient
// bit per stage, two stages for the rotation matrix and four for the scale,
// saturation and translation products.
// Throughput is one item per cycle while the receiver does not stall the output.
// The whole pipeline advances together. When the receiver holds i_ready low
// while a result is waiting, every stage holds and o_ready drops, so nothing
// is lost or repeated; empty stages do not hold anything back.
// Reset clears every stage valid bit; the data registers are left as they
// are and o_ready is high straight after reset.
`default_nettype none
module trs_transform_compose_unit
    import trs_tc_pkg::*;
(
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_valid,
    output logic              o_ready,
    input  wire  logic [1:0]  i_op,
    input  wire  logic [31:0] i_trans_x,
    input  wire  logic [31:0] i_trans_y,
    input  wire  logic [31:0] i_trans_z,
    input  wire  logic [31:0] i_scale_x,
    input  wire  logic [31:0] i_scale_y,
    input  wire  logic [31:0] i_scale_z,
    input  wire  logic [31:0] i_quat_w,
    input  wire  logic [31:0] i_quat_x,
    input  wire  logic [31:0] i_quat_y,
    input  wire  logic [31:0] i_quat_z,
    output logic              o_valid,
    input  wire  logic        i_ready,
    output logic [31:0]       o_m_c0_r0,
    output logic [31:0]       o_m_c0_r1,
    output logic [31:0]       o_m_c0_r2,
    output logic [31:0]       o_m_c1_r0,
    output logic [31:0]       o_m_c1_r1,
    output logic [31:0]       o_m_c1_r2,
    output logic [31:0]       o_m_c2_r0,
    output logic [31:0]       o_m_c2_r1,
    output logic [31:0]       o_m_c2_r2,
    output logic [31:0]       o_out_tx,
    output logic [31:0]       o_out_ty,
    output logic [31:0]       o_out_tz
);

    // A single enable moves every stage; it is low only when a finished
    // result sits in the output register and the receiver is not taking it.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    t_item in_item;
    always_comb begin
        in_item.op       = i_op;
        in_item.trans[0] = i_trans_x;
        in_item.trans[1] = i_trans_y;
        in_item.trans[2] = i_trans_z;
        in_item.scale[0] = i_scale_x;
        in_item.scale[1] = i_scale_y;
        in_item.scale[2] = i_scale_z;
        in_item.quat[0]  = i_quat_w;
        in_item.quat[1]  = i_quat_x;
        in_item.quat[2]  = i_quat_y;
        in_item.quat[3]  = i_quat_z;
    end

    // Reciprocal of the scale, built alongside the item itself.
    logic             div_valid;
    t_item            div_item;
    logic [2:0][32:0] div_quo;
    logic [2:0]       div_neg;
    logic [2:0]       div_zero;

    trs_tc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (in_item),
        .o_valid (div_valid),
        .o_item  (div_item),
        .o_quo   (div_quo),
        .o_neg   (div_neg),
        .o_zero  (div_zero)
    );

    // Rotation matrix from the quaternion, conjugated for the inverse modes.
    logic                 rot_valid;
    logic [1:0]           rot_op;
    logic [2:0][31:0]     rot_trans;
    logic [2:0][31:0]     rot_scale;
    logic [8:0][RotW-1:0] rot_mat;

    trs_tc_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_item  (div_item),
        .i_quo   (div_quo),
        .i_neg   (div_neg),
        .i_zero  (div_zero),
        .o_valid (rot_valid),
        .o_op    (rot_op),
        .o_trans (rot_trans),
        .o_scale (rot_scale),
        .o_rot   (rot_mat)
    );

    // Scaling, saturation and the translation column; ends in the output
    // register.
    logic [8:0][31:0] lin_m;
    logic [2:0][31:0] lin_t;

    trs_tc_lin u_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rot_valid),
        .i_op    (rot_op),
        .i_trans (rot_trans),
        .i_scale (rot_scale),
        .i_rot   (rot_mat),
        .o_valid (o_valid),
        .o_m     (lin_m),
        .o_t     (lin_t)
    );

    assign o_m_c0_r0 = lin_m[0];
    assign o_m_c0_r1 = lin_m[1];
    assign o_m_c0_r2 = lin_m[2];
    assign o_m_c1_r0 = lin_m[3];
    assign o_m_c1_r1 = lin_m[4];
    assign o_m_c1_r2 = lin_m[5];
    assign o_m_c2_r0 = lin_m[6];
    assign o_m_c2_r1 = lin_m[7];
    assign o_m_c2_r2 = lin_m[8];
    assign o_out_tx  = lin_t[0];
    assign o_out_ty  = lin_t[1];
    assign o_out_tz  = lin_t[2];

endmodule
`default_nettype wire

// ===== bench/trs_tc_checker.sv =====
module trs_tc_checker
    import trs_tc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [2:0][31:0] i_trans,
    input  logic [2:0][31:0] i_scale,
    input  logic [3:0][31:0] i_quat,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [11:0][31:0] o_matrix,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_matrices_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Entries 0..8 are the linear part, column major; 9..11 the translation.
    typedef logic [11:0][31:0] t_matrix;

    t_matrix matrix_queue[$];

    function automatic longint clamp32(longint v);
        if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
        if (v < -longint'(33'sh80000000)) return -longint'(33'sh80000000);
        return v;
    endfunction

    function automatic longint half_product(longint a, longint b, bit negate);
        longint p;
        p = a * b;
        if (negate) p = -p;
        return p >>> 1;
    endfunction

    function automatic longint rot_cross(longint a, longint b, longint c, longint d,
                                         bit negate);
        return (half_product(a, b, 0) + half_product(c, d, negate)) >>> 31;
    endfunction

    function automatic longint rot_diag(longint a, longint b);
        return ((longint'(1) <<< 58) - (half_product(a, a, 0) + half_product(b, b, 0)))
            >>> 31;
    endfunction

    function automatic longint recip_scale(longint s);
        if (s == 0) return longint'(32'sh7FFFFFFF);
        return clamp32((longint'(1) <<< 32) / s);
    endfunction

    function automatic t_matrix compose_matrix(logic [1:0] op, logic [2:0][31:0] tr,
                                               logic [2:0][31:0] sc, logic [3:0][31:0] q);
        longint t[3], s[3], rot[3][3], lin[3][3], tc[3], acc;
        longint w, x, y, z;
        t_matrix res;
        for (int c = 0; c < 3; c++) begin
            t[c] = longint'($signed(tr[c]));
            s[c] = longint'($signed(sc[c]));
        end
        w = longint'($signed(q[0]));
        x = longint'($signed(q[1]));
        y = longint'($signed(q[2]));
        z = longint'($signed(q[3]));
        if (op == OpInv || op == OpInvAxes) begin
            for (int c = 0; c < 3; c++) begin
                t[c] = -t[c];
                s[c] = recip_scale(s[c]);
            end
            x = -x;
            y = -y;
            z = -z;
        end
        rot[0][0] = rot_diag(y, z);
        rot[0][1] = rot_cross(x, y, w, z, 0);
        rot[0][2] = rot_cross(x, z, w, y, 1);
        rot[1][0] = rot_cross(x, y, w, z, 1);
        rot[1][1] = rot_diag(x, z);
        rot[1][2] = rot_cross(y, z, w, x, 0);
        rot[2][0] = rot_cross(x, z, w, y, 0);
        rot[2][1] = rot_cross(y, z, w, x, 1);
        rot[2][2] = rot_diag(x, y);
        if (op == OpFwd || op == OpInvAxes) begin
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 3; r++)
                    lin[c][r] = clamp32((rot[c][r] * s[c]) >>> 27);
            for (int r = 0; r < 3; r++) tc[r] = clamp32(t[r]);
        end else begin
            for (int c = 0; c < 3; c++)
                for (int r = 0; r < 3; r++)
                    lin[c][r] = clamp32((rot[c][r] * s[r]) >>> 27);
            for (int r = 0; r < 3; r++) begin
                acc = 0;
                for (int c = 0; c < 3; c++) acc += (lin[c][r] * t[c]) >>> 16;
                tc[r] = clamp32(acc);
            end
        end
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                res[c * 3 + r] = lin[c][r][31:0];
        for (int r = 0; r < 3; r++) res[9 + r] = tc[r][31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("%0t mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_matrices_seen = 0;
    end

    assign o_pending = matrix_queue.size();

    always @(posedge i_clk) begin
        t_matrix want;
        if (i_rst_n && i_valid && o_ready)
            matrix_queue.push_back(compose_matrix(i_op, i_trans, i_scale, i_quat));
        if (i_rst_n && o_valid && i_ready) begin
            o_matrices_seen++;
            if (matrix_queue.size() == 0) begin
                report_mismatch("matrix item with none expected");
            end else begin
                want = matrix_queue.pop_front();
                for (int k = 0; k < 12; k++)
                    if (o_matrix[k] !== want[k])
                        report_mismatch($sformatf("entry %0d got %h want %h",
                                                  k, o_matrix[k], want[k]));
            end
        end
    end
endmodule

// ===== bench/tb.sv =====
module tb;
    import trs_tc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid;
    logic [1:0] i_op = OpFwd;
    logic [2:0][31:0] trans = '0;
    logic [2:0][31:0] scale = '0;
    logic [3:0][31:0] quat = '0;
    logic [11:0][31:0] matrix;
    int fail_count, pending, matrices_seen;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;

    always #6 i_clk = ~i_clk;

    trs_transform_compose_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op),
        .i_trans_x(trans[0]), .i_trans_y(trans[1]), .i_trans_z(trans[2]),
        .i_scale_x(scale[0]), .i_scale_y(scale[1]), .i_scale_z(scale[2]),
        .i_quat_w(quat[0]), .i_quat_x(quat[1]), .i_quat_y(quat[2]), .i_quat_z(quat[3]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_m_c0_r0(matrix[0]), .o_m_c0_r1(matrix[1]), .o_m_c0_r2(matrix[2]),
        .o_m_c1_r0(matrix[3]), .o_m_c1_r1(matrix[4]), .o_m_c1_r2(matrix[5]),
        .o_m_c2_r0(matrix[6]), .o_m_c2_r1(matrix[7]), .o_m_c2_r2(matrix[8]),
        .o_out_tx(matrix[9]), .o_out_ty(matrix[10]), .o_out_tz(matrix[11])
    );

    trs_tc_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_trans(trans), .i_scale(scale), .i_quat(quat),
        .o_valid(o_valid), .i_ready(i_ready), .o_matrix(matrix),
        .o_fail_count(fail_count), .o_pending(pending), .o_matrices_seen(matrices_seen)
    );

    // The receiver decides its stall once per cycle, on the falling edge, so
    // that the value is stable by the next rising edge.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Presents one item on the falling edge and holds it until the rising edge
    // at which it is accepted. Idle cycles come first, with valid low; the
    // payload is only changed when a new item is presented.
    task automatic send_item(logic [1:0] op, logic [2:0][31:0] t, logic [2:0][31:0] s,
                             logic [3:0][31:0] q);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        trans <= t;
        scale <= s;
        quat <= q;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // A field value: fully random, small in magnitude, or one of the corners.
    function automatic logic [31:0] pick_word();
        int sel;
        logic [31:0] v;
        sel = $urandom_range(9);
        if (sel < 5) begin
            v = $urandom;
        end else if (sel < 8) begin
            v = $urandom_range(32'h0004_0000) - 32'h0002_0000;
        end else begin
            case ($urandom_range(5))
                0: v = 32'h0000_0000;
                1: v = 32'h0000_0001;
                2: v = 32'hFFFF_FFFF;
                3: v = 32'h8000_0000;
                4: v = 32'h7FFF_FFFF;
                default: v = 32'h0001_0000;
            endcase
        end
        return v;
    endfunction

    // Most quaternion components are drawn within half of unit magnitude,
    // with random sign and content; the rest come from pick_word.
    task automatic send_random_item();
        logic [2:0][31:0] t, s;
        logic [3:0][31:0] q;
        for (int k = 0; k < 3; k++) begin
            t[k] = pick_word();
            s[k] = pick_word();
        end
        for (int k = 0; k < 4; k++) begin
            if ($urandom_range(3) != 0)
                q[k] = $urandom_range(32'h4000_0000) - 32'h2000_0000;
            else
                q[k] = pick_word();
        end
        send_item(2'($urandom_range(3)), t, s, q);
    endtask

    initial begin
        logic [2:0][31:0] unit_scale;
        logic [3:0][31:0] ident_quat;
        logic [1:0] op;
        unit_scale = {3{32'h0001_0000}};
        ident_quat = {32'h0, 32'h0, 32'h0, 32'h4000_0000};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed items: every operation with an identity rotation and unit
        // scale, then the corners of translation, scale and quaternion.
        for (int k = 0; k < 4; k++) begin
            op = 2'(k);
            send_item(op, {32'h0003_0000, 32'hFFFE_0000, 32'h0001_8000}, unit_scale,
                      ident_quat);
            // Most negative translation, negated internally in the inverse operations.
            send_item(op, {3{32'h8000_0000}}, unit_scale, ident_quat);
            // Zero scale: its reciprocal saturates.
            send_item(op, {3{32'h0001_0000}}, {32'h0, 32'h0, 32'h0}, ident_quat);
            // Extreme scales and a full-scale quaternion exercise output saturation.
            send_item(op, {3{32'h7FFF_FFFF}},
                      {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001},
                      {4{32'h8000_0000}});
            send_item(op, {3{32'hFFFF_FFFF}}, {32'hFFFF_FFFF, 32'h8000_0000, 32'h1},
                      {4{32'h7FFF_FFFF}});
        end
        send_item(OpAxes, '0, '0, '0);

        // Random items in four handshake phases.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0; stall_pct = 0; end
                1: begin idle_pct = 67; stall_pct = 0; end
                2: begin idle_pct = 0; stall_pct = 67; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            repeat (100) send_random_item();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        stall_pct = 0;

        // Drain the pipeline, then allow its latency again for any stray item.
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Sent %0d items over all four operations, %0d matrices checked,",
                 items_sent, matrices_seen);
        $display("with sender idling and receiver stalling in four handshake phases.");
        if (fail_count == 0) begin
            $display("[trs_transform_compose_unit] OK");
        end else begin
            $display("[trs_transform_compose_unit] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2ms;
        $display("[trs_transform_compose_unit] ERROR");
        $finish;
    end
endmodule

// ===== files.f =====
sv/trs_tc_pkg.sv
sv/trs_tc_div.sv
sv/trs_tc_rot.sv
sv/trs_tc_lin.sv
sv/trs_transform_compose_unit.sv
bench/trs_tc_checker.sv
bench/tb.sv
